FILE: design/rpn_calc_pkg.sv
// Shared types and constants for the postfix add/multiply evaluator.
// No dependencies; imported by every module of the block.
package rpn_calc_pkg;

    localparam int DATA_W          = 32;
    localparam int CHAR_W          = 8;
    localparam int DIGIT_W         = 4;
    localparam int DEF_STACK_DEPTH = 64;

    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'd57;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'd43;
    localparam logic [CHAR_W-1:0] CH_STAR    = 8'd42;

    typedef logic [DATA_W-1:0] word_t;

    typedef enum logic [1:0] {
        STK_HOLD = 2'd0,
        STK_PUSH = 2'd1,
        STK_REPL = 2'd2,
        STK_UPWR = 2'd3
    } stk_op_t;

    typedef struct packed {
        stk_op_t op;
        logic    rot;
    } cell_ctrl_t;

endpackage

FILE: design/rpn_calc_cell.sv
// One operand stack cell of the shifting stack chain.
// Depends on rpn_calc_pkg for the cell control struct and word type.
module rpn_calc_cell
    import rpn_calc_pkg::*;
#(
    parameter bit IS_TOP    = 1'b0,
    parameter bit IS_BOTTOM = 1'b0
)
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  word_t      wr_value,
    input  word_t      spill_value,
    input  word_t      prev_data,
    input  word_t      next_data,
    input  word_t      next_post,
    output word_t      data,
    output word_t      post
);

    word_t data_reg;
    word_t data_next;

    always_comb
    begin
        case (ctrl.op)
            STK_PUSH: post = IS_TOP ? wr_value : prev_data;
            STK_REPL: post = IS_TOP ? wr_value : (IS_BOTTOM ? spill_value : data_reg);
            STK_UPWR: post = IS_TOP ? wr_value : next_data;
            default:  post = data_reg;
        endcase
        data_next = ctrl.rot ? next_post : post;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: design/rpn_calc_ctrl.sv
// Character decode, pending number, stack pointer, ALU and realign counter.
// Depends on rpn_calc_pkg; drives the cell chain and the output buffer.
module rpn_calc_ctrl
    import rpn_calc_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              last,
    input  logic              out_room,
    input  word_t             tos,
    input  word_t             nos,
    input  word_t             post_top,
    output logic              in_ready,
    output cell_ctrl_t        ctrl,
    output word_t             wr_value,
    output word_t             spill_value,
    output logic              res_push,
    output word_t             res_value
);

    localparam int PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(STACK_DEPTH - 1);

    logic [PTR_W-1:0] ptr_reg, ptr_next, ptr_after;
    logic [PTR_W-1:0] realign_reg, realign_next;
    word_t            pend_reg, pend_next, pend_x10, alu_a, alu_b, alu_out;
    logic             inprog_reg, inprog_next;
    logic             accept, is_digit, is_sep, is_op, ends;
    stk_op_t          stk_op;
    logic             stk_rot;

    assign in_ready = (realign_reg == '0) && out_room;
    assign accept   = in_valid && in_ready;
    assign ends     = accept && last;
    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign is_sep   = (char_code == CH_SPACE) || (char_code == CH_NEWLINE);
    assign is_op    = (char_code == CH_PLUS) || (char_code == CH_STAR);
    assign pend_x10 = {pend_reg[DATA_W-4:0], 3'b000} + {pend_reg[DATA_W-2:0], 1'b0};
    assign alu_a    = inprog_reg ? tos : nos;
    assign alu_b    = inprog_reg ? pend_reg : tos;
    assign alu_out  = (char_code == CH_PLUS) ? alu_a + alu_b : alu_a * alu_b;

    always_comb
    begin
        stk_op      = STK_HOLD;
        wr_value    = pend_reg;
        pend_next   = pend_reg;
        inprog_next = inprog_reg;
        if (accept)
        begin
            if (is_digit)
            begin
                pend_next   = pend_x10 + DATA_W'(char_code[DIGIT_W-1:0]);
                inprog_next = 1'b1;
                if (last)
                begin
                    stk_op   = STK_PUSH;
                    wr_value = pend_next;
                end
            end
            else if (is_op)
            begin
                stk_op      = inprog_reg ? STK_REPL : STK_UPWR;
                wr_value    = alu_out;
                pend_next   = '0;
                inprog_next = 1'b0;
            end
            else if (is_sep || last)
            begin
                if (inprog_reg)
                begin
                    stk_op = STK_PUSH;
                end
                pend_next   = '0;
                inprog_next = 1'b0;
            end
        end
        if (ends)
        begin
            pend_next   = '0;
            inprog_next = 1'b0;
        end
    end

    always_comb
    begin
        case (stk_op)
            STK_PUSH: ptr_after = (ptr_reg == PTR_MAX) ? '0 : ptr_reg + 1'b1;
            STK_UPWR: ptr_after = (ptr_reg == '0) ? PTR_MAX : ptr_reg - 1'b1;
            default:  ptr_after = ptr_reg;
        endcase
        ptr_next     = ptr_after;
        realign_next = (realign_reg == '0) ? '0 : realign_reg - 1'b1;
        stk_rot      = (realign_reg != '0);
        if (ends)
        begin
            ptr_next     = '0;
            stk_rot      = (ptr_after != '0);
            realign_next = (ptr_after == '0) ? '0 : ptr_after - 1'b1;
        end
    end

    assign ctrl        = '{op: stk_op, rot: stk_rot};
    assign spill_value = pend_reg;
    assign res_push    = ends;
    assign res_value   = post_top;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            realign_reg <= '0;
            pend_reg    <= '0;
            inprog_reg  <= 1'b0;
        end
        else
        begin
            ptr_reg     <= ptr_next;
            realign_reg <= realign_next;
            pend_reg    <= pend_next;
            inprog_reg  <= inprog_next;
        end
    end

endmodule

FILE: design/rpn_calc_obuf.sv
// Two-entry result buffer (head plus skid) in front of the master stream.
// Depends on rpn_calc_pkg for the word type.
module rpn_calc_obuf
    import rpn_calc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  word_t push_data,
    input  logic  pop_ready,
    output logic  room,
    output logic  head_valid,
    output word_t head_data
);

    logic [1:0] cnt_reg, cnt_next;
    word_t      head_reg, head_next, skid_reg, skid_next;
    logic       pop;

    assign head_valid = (cnt_reg != 2'd0);
    assign head_data  = head_reg;
    assign room       = (cnt_reg != 2'd2);
    assign pop        = head_valid && pop_ready;

    always_comb
    begin
        head_next = head_reg;
        skid_next = skid_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
        if (pop)
        begin
            head_next = (cnt_reg == 2'd2) ? skid_reg : push_data;
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                head_next = push_data;
            end
            else
            begin
                skid_next = push_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: design/postfix_add_mul_evaluator_top.sv
// Postfix add/multiply evaluator: one ASCII character per input beat, one result
// beat per expression. The operand stack is a ring of STACK_DEPTH cells that shift
// together, top of stack always in cell 0; a character is accepted every cycle
// while no realignment runs and the result buffer has room. A beat with tlast also
// emits the result; if the stack then holds P entries (modulo STACK_DEPTH, P > 1)
// the ring rotates back into place with s_axis_tready held low, so a well-formed
// expression leaving one value does not stall the input. Results wait in a two-beat
// buffer. Depends on rpn_calc_pkg, rpn_calc_ctrl, rpn_calc_cell, rpn_calc_obuf.
module postfix_add_mul_evaluator_top
    import rpn_calc_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,  // [7:0] char_code
    input  logic                     s_axis_tlast,  // end_of_expression
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic signed [DATA_W-1:0] m_axis_tdata   // [31:0] result_value
);

    cell_ctrl_t ctrl;
    word_t      wr_value, spill_value, res_value, head_data;
    word_t      cell_data [STACK_DEPTH];
    word_t      cell_post [STACK_DEPTH];
    logic       res_push, room;

    rpn_calc_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .char_code   (s_axis_tdata[CHAR_W-1:0]),
        .last        (s_axis_tlast),
        .out_room    (room),
        .tos         (cell_data[0]),
        .nos         (cell_data[1]),
        .post_top    (cell_post[0]),
        .in_ready    (s_axis_tready),
        .ctrl        (ctrl),
        .wr_value    (wr_value),
        .spill_value (spill_value),
        .res_push    (res_push),
        .res_value   (res_value)
    );

    for (genvar k = 0; k < STACK_DEPTH; k++)
    begin : g_cell
        localparam int PREV = (k + STACK_DEPTH - 1) % STACK_DEPTH;
        localparam int NEXT = (k + 1) % STACK_DEPTH;

        rpn_calc_cell #(
            .IS_TOP    (k == 0),
            .IS_BOTTOM (k == STACK_DEPTH - 1)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .wr_value    (wr_value),
            .spill_value (spill_value),
            .prev_data   (cell_data[PREV]),
            .next_data   (cell_data[NEXT]),
            .next_post   (cell_post[NEXT]),
            .data        (cell_data[k]),
            .post        (cell_post[k])
        );
    end

    rpn_calc_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_push),
        .push_data  (res_value),
        .pop_ready  (m_axis_tready),
        .room       (room),
        .head_valid (m_axis_tvalid),
        .head_data  (head_data)
    );

    assign m_axis_tdata = $signed(head_data);

endmodule

FILE: tb/postfix_scoreboard_pkg.sv
// Scoreboard class for the postfix add/multiply evaluator testbench.
// Predicts the result of every ended expression and checks result beats in order.
// Depends on rpn_calc_pkg.
package postfix_scoreboard_pkg;
    import rpn_calc_pkg::*;

    class postfix_scoreboard;
        word_t                      stack_words [DEF_STACK_DEPTH];
        bit [DEF_STACK_DEPTH-1:0]   filled;
        int                         sp;
        word_t                      pend;
        bit                         busy;
        word_t                      expected_values [$];
        int                         mismatches;
        int                         beats;
        int                         useful;
        int                         results_seen;
        int                         operators;
        int                         wraps;

        function new();
            filled       = '0;
            sp           = 0;
            pend         = '0;
            busy         = 1'b0;
            mismatches   = 0;
            beats        = 0;
            useful       = 0;
            results_seen = 0;
            operators    = 0;
            wraps        = 0;
            foreach (stack_words[i])
                stack_words[i] = '0;
        endfunction

        function int nxt(int p);
            return (p + 1 >= DEF_STACK_DEPTH) ? 0 : p + 1;
        endfunction

        function int prv(int p);
            return (p == 0) ? DEF_STACK_DEPTH - 1 : p - 1;
        endfunction

        function void push(word_t v);
            stack_words[sp] = v;
            filled[sp]      = 1'b1;
            if (sp == DEF_STACK_DEPTH - 1)
                wraps++;
            sp = nxt(sp);
        endfunction

        function word_t pop();
            sp = prv(sp);
            return stack_words[sp];
        endfunction

        function void flush();
            if (busy)
            begin
                push(pend);
                pend = '0;
                busy = 1'b0;
            end
        endfunction

        // true when the beat touches only slots that hold a written value
        function bit reads_defined(logic [CHAR_W-1:0] c, bit last);
            bit [DEF_STACK_DEPTH-1:0] w;
            int                       p;
            bit                       n;
            w = filled;
            p = sp;
            n = busy;
            if (c >= CH_ZERO && c <= CH_NINE)
                n = 1'b1;
            else if (c == CH_SPACE || c == CH_NEWLINE || c == CH_PLUS || c == CH_STAR)
            begin
                if (n)
                begin
                    w[p] = 1'b1;
                    p    = nxt(p);
                    n    = 1'b0;
                end
                if (c == CH_PLUS || c == CH_STAR)
                begin
                    p = prv(p);
                    if (!w[p])
                        return 1'b0;
                    p = prv(p);
                    if (!w[p])
                        return 1'b0;
                    w[p] = 1'b1;
                    p    = nxt(p);
                end
            end
            if (last)
            begin
                if (n)
                begin
                    w[p] = 1'b1;
                    p    = nxt(p);
                end
                return w[prv(p)];
            end
            return 1'b1;
        endfunction

        function void note_char(logic [CHAR_W-1:0] c, bit last);
            word_t a;
            word_t b;
            beats++;
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                pend = pend * 32'd10 + 32'(c - CH_ZERO);
                busy = 1'b1;
                useful++;
            end
            else if (c == CH_SPACE || c == CH_NEWLINE)
            begin
                flush();
                useful++;
            end
            else if (c == CH_PLUS || c == CH_STAR)
            begin
                flush();
                b = pop();
                a = pop();
                push((c == CH_PLUS) ? a + b : a * b);
                operators++;
                useful++;
            end
            if (last)
            begin
                flush();
                expected_values.push_back(stack_words[prv(sp)]);
                sp   = 0;
                pend = '0;
                busy = 1'b0;
            end
        endfunction

        function void check_result(word_t got);
            word_t want;
            if (expected_values.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: got 0x%08h", got);
                return;
            end
            want = expected_values.pop_front();
            results_seen++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d mismatch: expected 0x%08h (%0d), got 0x%08h (%0d)",
                             results_seen, want, $signed(want), got, $signed(got));
            end
        endfunction
    endclass

endpackage

FILE: tb/tb_postfix_add_mul_evaluator_top.sv
// Testbench top for postfix_add_mul_evaluator_top: directed and random character
// streams with random idling on both stream sides, checked by postfix_scoreboard.
// Depends on rpn_calc_pkg, postfix_scoreboard_pkg and the design files.
module tb_postfix_add_mul_evaluator_top;
    import rpn_calc_pkg::*;
    import postfix_scoreboard_pkg::*;

    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [7:0]               s_axis_tdata;
    logic                     s_axis_tlast;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic signed [DATA_W-1:0] m_axis_tdata;

    postfix_scoreboard sb;
    int                src_idle;
    int                sink_idle = 0;

    postfix_add_mul_evaluator_top #(
        .STACK_DEPTH(DEF_STACK_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(8 * 300000);
        $display("timed out waiting for the block");
        $display("tb_postfix_add_mul_evaluator_top: errors");
        $finish;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle);

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(word_t'(m_axis_tdata));

    function automatic logic [CHAR_W-1:0] pick_ignored();
        logic [CHAR_W-1:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_SPACE || c == CH_NEWLINE ||
               c == CH_PLUS || c == CH_STAR);
        return c;
    endfunction

    task automatic send_char(logic [CHAR_W-1:0] c, bit last);
        // replace a beat that would read a never-written slot
        if (!sb.reads_defined(c, last))
            c = CH_ZERO + 8'($urandom_range(0, 9));
        if ($urandom_range(0, 99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_char(c, last);
    endtask

    task automatic send_text(string s, bit last);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], last && (i == s.len() - 1));
    endtask

    task automatic send_wellformed(int nums, bit reduce, bit deep);
        logic [CHAR_W-1:0] q [$];
        int                depth;
        int                left;
        int                nd;
        bit                open;
        depth = 0;
        left  = nums;
        open  = 1'b0;
        while (left > 0 || (reduce && depth > 1))
        begin
            if (depth >= 2 && (left == 0 || (!deep && $urandom_range(0, 99) < 45)))
            begin
                q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_STAR);
                depth--;
                open = 1'b0;
            end
            else
            begin
                if (open)
                    q.push_back(($urandom_range(0, 3) == 0) ? CH_NEWLINE : CH_SPACE);
                nd = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 11) : $urandom_range(1, 3);
                repeat (nd)
                    q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                open = 1'b1;
                left--;
                depth++;
            end
            if ($urandom_range(0, 19) == 0)
                q.push_back(pick_ignored());
            if ($urandom_range(0, 9) == 0)
            begin
                q.push_back(CH_SPACE);
                open = 1'b0;
            end
        end
        case ($urandom_range(0, 3))
            1: q.push_back(($urandom_range(0, 1) == 0) ? CH_NEWLINE : CH_SPACE);
            2: q.push_back(pick_ignored());
            default: ;
        endcase
        foreach (q[i])
            send_char(q[i], i == q.size() - 1);
    endtask

    task automatic send_garbage(int n);
        logic [CHAR_W-1:0] c;
        int                pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                c = CH_ZERO + 8'($urandom_range(0, 9));
            else if (pick < 45)
                c = ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_NEWLINE;
            else if (pick < 65)
                c = ($urandom_range(0, 1) == 0) ? CH_PLUS : CH_STAR;
            else
                c = 8'($urandom_range(0, 255));
            send_char(c, i == n - 1);
        end
    endtask

    initial
    begin
        int goal;
        int pick;
        sb = new();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        src_idle = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("9", 1'b1);
        send_text("7 8*", 1'b1);
        send_char(8'h00, 1'b0);
        send_text("1", 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("0  5+", 1'b1);
        send_text("4294967299\n", 1'b1);

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle = 19;
                    sink_idle <= 61;
                end
                1:
                begin
                    src_idle = 61;
                    sink_idle <= 19;
                end
                default:
                begin
                    src_idle = 0;
                    sink_idle <= 0;
                end
            endcase
            // push past the stack depth so the pointer wraps
            if (ph == 1)
                send_wellformed(66 + $urandom_range(0, 6), 1'b1, 1'b1);
            goal = sb.useful + 130;
            while (sb.useful < goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    send_wellformed($urandom_range(1, 6), $urandom_range(0, 3) != 0, 1'b0);
                else
                    send_garbage($urandom_range(1, 8));
            end
            // hold the sender until every result has drained
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while (sb.expected_values.size() != 0)
                @(posedge clk);
        end

        repeat (2 * DEF_STACK_DEPTH + 16) @(posedge clk);

        $display("covered %0d beats (%0d ignored characters), %0d operators, %0d stack wraps",
                 sb.beats, sb.beats - sb.useful, sb.operators, sb.wraps);
        $display("checked %0d results, %0d mismatches, %0d still outstanding",
                 sb.results_seen, sb.mismatches, sb.expected_values.size());
        if (sb.mismatches == 0 && sb.expected_values.size() == 0)
            $display("tb_postfix_add_mul_evaluator_top: clean");
        else
            $display("tb_postfix_add_mul_evaluator_top: errors");
        $finish;
    end

endmodule
